[hw/rtl/b64d_pkg.sv]
// Shared types, codes and helper functions of the base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] CHAR_PAD  = 8'h3D;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    STOP_EOT = 2'd0,
    STOP_PAD = 2'd1,
    STOP_BAD = 2'd2
  } stop_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_in_run;
    logic        message_done;
    stop_t       stop_reason;
    logic [15:0] byte_count;
  } rec_t;

  // results of one request: recs[0] goes out first, n is 1..3
  typedef struct packed {
    rec_t [2:0] recs;
    logic [1:0] n;
  } group_t;

  // {invalid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'h40;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r = {1'b0, ch[5:0] - 6'd1};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r = {1'b0, ch[5:0] - 6'd7};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, ch[5:0] + 6'd4};
    end else if (ch == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (ch == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

[hw/rtl/b64d_decode.sv]
// Input register, decoder state and per-request result group logic.
module b64d_decode import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_char,
  input  logic       in_eot,
  output logic       grp_valid,
  input  logic       grp_ready,
  output group_t     grp
);

  logic        inq_v_r;
  logic [7:0]  inq_char_r;
  logic        inq_eot_r;

  logic [17:0] pend_r, pend_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        stopped_r, stopped_nxt;
  stop_t       cause_r, cause_nxt;
  logic [15:0] total_r, total_nxt;

  logic        advance;
  logic        in_fire;

  always_comb begin
    logic [6:0]  sx;
    logic        vld;
    logic [17:0] newpend;
    logic [17:0] fp;
    logic [1:0]  fpos;
    logic [1:0]  nb;
    logic [7:0]  b [3];
    logic [15:0] c [3];
    stop_t       cause_eff;
    logic [1:0]  n;

    sx        = sextet_of(inq_char_r);
    vld       = !sx[6];
    newpend   = {pend_r[11:0], sx[5:0]};
    nb        = 2'd0;
    b[0]      = 8'd0;
    b[1]      = 8'd0;
    b[2]      = 8'd0;
    cause_eff = cause_r;
    fp        = vld ? newpend : pend_r;
    fpos      = vld ? pos_r + 2'd1 : pos_r;

    pend_nxt    = pend_r;
    pos_nxt     = pos_r;
    stopped_nxt = stopped_r;
    cause_nxt   = cause_r;

    if (!stopped_r) begin
      if (vld && pos_r == 2'd3) begin
        nb       = 2'd3;
        b[0]     = pend_r[17:10];
        b[1]     = pend_r[9:2];
        b[2]     = {pend_r[1:0], sx[5:0]};
        pend_nxt = 18'd0;
        pos_nxt  = 2'd0;
      end else begin
        if (vld) begin
          pend_nxt = newpend;
          pos_nxt  = fpos;
        end else begin
          stopped_nxt = 1'b1;
          cause_eff   = (inq_char_r == CHAR_PAD) ? STOP_PAD : STOP_BAD;
          cause_nxt   = cause_eff;
          pend_nxt    = 18'd0;
          pos_nxt     = 2'd0;
        end
        if (!vld || inq_eot_r) begin
          if (fpos == 2'd2) begin
            nb   = 2'd1;
            b[0] = fp[11:4];
          end else if (fpos == 2'd3) begin
            nb   = 2'd2;
            b[0] = fp[17:10];
            b[1] = fp[9:2];
          end
        end
      end
    end

    c[0] = sat_inc(total_r);
    c[1] = sat_inc(c[0]);
    c[2] = sat_inc(c[1]);

    unique case (nb)
      2'd0:    total_nxt = total_r;
      2'd1:    total_nxt = c[0];
      2'd2:    total_nxt = c[1];
      default: total_nxt = c[2];
    endcase

    for (int i = 0; i < 3; i++) begin
      grp.recs[i].byte_valid   = (2'(i) < nb);
      grp.recs[i].data_byte    = (2'(i) < nb) ? b[i] : 8'd0;
      grp.recs[i].byte_count   = c[i];
      grp.recs[i].last_in_run  = 1'b0;
      grp.recs[i].message_done = 1'b0;
      grp.recs[i].stop_reason  = STOP_EOT;
    end

    n = nb;
    if (inq_eot_r && nb == 2'd0) begin
      n                        = 2'd1;
      grp.recs[0].byte_count   = total_r;
    end
    grp.n = n;

    for (int i = 0; i < 3; i++) begin
      if (n != 2'd0 && 2'(i) == n - 2'd1) begin
        grp.recs[i].last_in_run  = 1'b1;
        grp.recs[i].message_done = inq_eot_r;
        grp.recs[i].stop_reason  = inq_eot_r ? cause_eff : STOP_EOT;
      end
    end

    if (inq_eot_r) begin
      pend_nxt    = 18'd0;
      pos_nxt     = 2'd0;
      stopped_nxt = 1'b0;
      cause_nxt   = STOP_EOT;
      total_nxt   = 16'd0;
    end
  end

  assign grp_valid = inq_v_r && (grp.n != 2'd0);
  assign advance   = inq_v_r && ((grp.n == 2'd0) || grp_ready);
  assign in_tready = !inq_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r   <= 1'b0;
      pend_r    <= 18'd0;
      pos_r     <= 2'd0;
      stopped_r <= 1'b0;
      cause_r   <= STOP_EOT;
      total_r   <= 16'd0;
    end else begin
      if (in_fire) begin
        inq_v_r <= 1'b1;
      end else if (advance) begin
        inq_v_r <= 1'b0;
      end
      if (advance) begin
        pend_r    <= pend_nxt;
        pos_r     <= pos_nxt;
        stopped_r <= stopped_nxt;
        cause_r   <= cause_nxt;
        total_r   <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_char_r <= in_char;
      inq_eot_r  <= in_eot;
    end
  end

endmodule

[hw/rtl/b64d_emit.sv]
// Two-entry result group queue and output serializer, one result per cycle while out_tready is high.
module b64d_emit import b64d_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   grp_valid,
  output logic   grp_ready,
  input  group_t grp,
  output logic   out_tvalid,
  input  logic   out_tready,
  output rec_t   out_rec
);

  group_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;

  group_t     head;
  logic       push;
  logic       out_fire;
  logic       pop;

  assign grp_ready  = (cnt_r != 2'd2);
  assign push       = grp_valid && grp_ready;
  assign head       = mem_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_rec    = head.recs[idx_r];
  assign out_fire   = out_tvalid && out_tready;
  assign pop        = out_fire && (idx_r == head.n - 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
        idx_r    <= 2'd0;
      end else if (out_fire) begin
        idx_r <= idx_r + 2'd1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= grp;
    end
  end

endmodule

[hw/rtl/base64_stream_decoder.sv]
// Top level of the base64 stream decoder.
//
//  channel | dir | tdata                          | tuser                              | tlast
//  in_     | in  | [7:0] text_char                | -                                  | end_of_text
//  out_    | out | [7:0] data_byte, [23:8] count  | [0] byte_valid, [1] message_done,  | last_in_run
//          |     |                                | [3:2] stop_reason                  |
//
// A request is taken into the input register, decoded in the next cycle and its
// results queued as one group in a two-entry queue; one result leaves per cycle
// while out_tready is high. Results pass the input register and the queue; a
// request with no result never enters the queue. Sustained input rate is one
// request per cycle while the output keeps up; the output port (one result per
// cycle) sets the limit. Reset (synchronous, rst_n low) clears decoder state and queue.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [23:8] byte_count
  output logic [3:0]  out_tuser,  // [0] byte_valid, [1] message_done, [3:2] stop_reason
  output logic        out_tlast   // last_in_run
);

  logic   grp_valid;
  logic   grp_ready;
  group_t grp;
  rec_t   out_rec;

  b64d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_eot    (in_tlast),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  b64d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_rec    (out_rec)
  );

  assign out_tdata = {out_rec.byte_count, out_rec.data_byte};
  assign out_tuser = {out_rec.stop_reason, out_rec.message_done, out_rec.byte_valid};
  assign out_tlast = out_rec.last_in_run;

endmodule

[tb/sv/tb.sv]
// Self-checking stream testbench for the base64 stream decoder.
`timescale 1ns / 1ps

module tb;
  import b64d_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 410;

  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_QUIET   = 2'd1,
    ROW_DONE    = 2'd2
  } row_kind_t;

  // one request plus, for typed rows, its expected outcome
  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    row_kind_t   kind;
    stop_t       stop;
    logic [15:0] cnt;
  } row_t;

  localparam row_t DIRECTED [24] = '{
    '{8'h41, 1'b1, ROW_DONE,    STOP_EOT, 16'd0},  // lone sextet flushes nothing
    '{8'h3D, 1'b1, ROW_DONE,    STOP_PAD, 16'd0},
    '{8'hFF, 1'b1, ROW_DONE,    STOP_BAD, 16'd0},
    '{8'h00, 1'b0, ROW_QUIET,   STOP_EOT, 16'd0},
    '{8'h5A, 1'b0, ROW_QUIET,   STOP_EOT, 16'd0},  // ignored after stop
    '{8'h61, 1'b1, ROW_DONE,    STOP_BAD, 16'd0},
    '{8'h2F, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h2B, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h7A, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h39, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h30, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h5A, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h3D, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},  // pad flushes two sextets
    '{8'h41, 1'b1, ROW_PREDICT, STOP_EOT, 16'd0},  // done on its own
    '{8'h54, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h57, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h46, 1'b1, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h54, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h57, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h46, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h75, 1'b1, ROW_PREDICT, STOP_EOT, 16'd0},  // done rides on third byte
    '{8'h51, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h51, 1'b0, ROW_PREDICT, STOP_EOT, 16'd0},
    '{8'h21, 1'b1, ROW_PREDICT, STOP_EOT, 16'd0}   // stop and end together
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  row_t        drv_row = '0;
  rec_t        bytes_due [$];
  int          errs = 0;
  int          live_items = 0;
  int          idle_cycles = 0;
  logic [9:0]  rx_cyc = '0;
  int          burst_left = 0;

  // predictor state
  logic [17:0] pend = '0;
  logic [1:0]  npend = '0;
  logic        halted = 1'b0;
  stop_t       cause = STOP_EOT;
  logic [15:0] total = '0;
  rec_t        step_res [3];
  int          step_n;

  base64_stream_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // {not in alphabet, sextet}
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B) return 7'd62;
    if (c == 8'h2F) return 7'd63;
    return 7'h40;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s - 6'd26);
    if (s < 6'd62) return 8'h30 + 8'(s - 6'd52);
    return (s == 6'd62) ? 8'h2B : 8'h2F;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    if (total != COUNT_MAX) total++;
    step_res[step_n] = '{b, 1'b1, 1'b0, 1'b0, STOP_EOT, total};
    step_n++;
  endtask

  task automatic flush_pending();
    if (npend == 2'd2) begin
      emit_byte(pend[11:4]);
    end else if (npend == 2'd3) begin
      emit_byte(pend[17:10]);
      emit_byte(pend[9:2]);
    end
    pend = '0;
    npend = '0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eot);
    logic [6:0] sx;
    sx = char_sextet(c);
    step_n = 0;
    if (!halted) begin
      if (!sx[6]) begin
        if (npend == 2'd3) begin
          emit_byte(pend[17:10]);
          emit_byte(pend[9:2]);
          emit_byte({pend[1:0], sx[5:0]});
          pend = '0;
          npend = '0;
        end else begin
          pend = {pend[11:0], sx[5:0]};
          npend++;
        end
      end else begin
        halted = 1'b1;
        cause = (c == CHAR_PAD) ? STOP_PAD : STOP_BAD;
        flush_pending();
      end
    end
    if (eot) begin
      if (!halted) flush_pending();
      if (step_n == 0) begin
        step_res[0] = '{8'h00, 1'b0, 1'b0, 1'b0, STOP_EOT, total};
        step_n = 1;
      end
      step_res[step_n-1].message_done = 1'b1;
      step_res[step_n-1].stop_reason = cause;
      pend = '0;
      npend = '0;
      halted = 1'b0;
      cause = STOP_EOT;
      total = '0;
    end
    if (step_n > 0) step_res[step_n-1].last_in_run = 1'b1;
  endtask

  task automatic mismatch(input string field, input int unsigned want, input int unsigned got);
    errs++;
    if (errs <= 40) $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // drive one request, then maybe open a gap once the burst is used up
  task automatic send(input row_t r);
    int gap;
    drv_row <= r;
    in_tdata <= r.ch;
    in_tlast <= r.eot;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 10'd1;
      case (rx_cyc[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= (rx_cyc[2:0] != 3'd5) && (rx_cyc[2:0] != 3'd6);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : in_mon
    if (rst_n && in_tvalid && in_tready) begin
      live_items++;
      decode_char(in_tdata, in_tlast);
      case (drv_row.kind)
        ROW_PREDICT: for (int k = 0; k < step_n; k++) bytes_due.push_back(step_res[k]);
        ROW_DONE: bytes_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1, drv_row.stop, drv_row.cnt});
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : out_mon
    rec_t want;
    rec_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.data_byte    = out_tdata[7:0];
      seen.byte_count   = out_tdata[23:8];
      seen.byte_valid   = out_tuser[0];
      seen.message_done = out_tuser[1];
      seen.stop_reason  = stop_t'(out_tuser[3:2]);
      seen.last_in_run  = out_tlast;
      if (bytes_due.size() == 0) begin
        errs++;
        if (errs <= 40) $error("result with nothing expected: data_byte %0d", seen.data_byte);
      end else begin
        want = bytes_due.pop_front();
        if (seen.data_byte != want.data_byte)
          mismatch("data_byte", want.data_byte, seen.data_byte);
        if (seen.byte_valid != want.byte_valid)
          mismatch("byte_valid", want.byte_valid, seen.byte_valid);
        if (seen.last_in_run != want.last_in_run)
          mismatch("last_in_run", want.last_in_run, seen.last_in_run);
        if (seen.message_done != want.message_done)
          mismatch("message_done", want.message_done, seen.message_done);
        if (seen.stop_reason != want.stop_reason)
          mismatch("stop_reason", want.stop_reason, seen.stop_reason);
        if (seen.byte_count != want.byte_count)
          mismatch("byte_count", want.byte_count, seen.byte_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    logic [7:0] msg [$];
    logic [7:0] c;
    logic [6:0] sx;
    int len;
    int tail;
    int extra;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[k]) send(DIRECTED[k]);
    // hold off until the decoder has drained
    settle();

    while (live_items < RANDOM_REQUESTS) begin
      msg.delete();
      len = $urandom_range(1, 18);
      tail = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) msg.push_back(b64_char(6'($urandom_range(0, 63))));
      case (tail)
        4: msg.push_back(CHAR_PAD);
        5: begin
          msg.push_back(CHAR_PAD);
          msg.push_back(CHAR_PAD);
        end
        6: begin
          msg.push_back(CHAR_PAD);
          extra = $urandom_range(1, 3);
          repeat (extra) msg.push_back(8'($urandom_range(0, 255)));
        end
        7: msg.push_back(8'($urandom_range(0, 255)));
        8: begin
          do begin
            c = 8'($urandom_range(0, 255));
            sx = char_sextet(c);
          end while (!sx[6]);
          msg[$urandom_range(0, len - 1)] = c;
        end
        9: foreach (msg[i]) msg[i] = 8'($urandom_range(0, 255));
        default: ;
      endcase
      foreach (msg[i]) send('{msg[i], 1'(i == msg.size() - 1), ROW_PREDICT, STOP_EOT, 16'd0});
    end

    settle();
    repeat (8) @(posedge clk);
    if (errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
